/* hdl/verlet_circle_particle_defines.svh */
// Assertion macros shared by the particle block
`ifndef VERLET_CIRCLE_PARTICLE_DEFINES_SVH
`define VERLET_CIRCLE_PARTICLE_DEFINES_SVH
// Implication checked every clock, quiet during reset
`define VCP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%s failed", "label");
// Next-cycle implication checked every clock, quiet during reset
`define VCP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%s failed", "label");
`endif

/* hdl/vcp_pkg.sv */
package vcp_pkg;
    localparam logic [2:0] REQ_ACCEL   = 3'd0;
    localparam logic [2:0] REQ_STEP    = 3'd1;
    localparam logic [2:0] REQ_CLAMP   = 3'd2;
    localparam logic [2:0] REQ_TEST    = 3'd3;
    localparam logic [2:0] REQ_RESOLVE = 3'd4;
    localparam logic [2:0] REQ_SETVEL  = 3'd5;
    localparam logic [2:0] REQ_ADDVEL  = 3'd6;
    localparam logic [2:0] REQ_SETPOS  = 3'd7;

    localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
    localparam logic [1:0] CFG_BODY_RADIUS  = 2'd1;
    localparam logic [1:0] CFG_WORLD_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_WORLD_HEIGHT = 2'd3;

    localparam int DT_FRAC   = 24;
    localparam int NORM_FRAC = 29;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // divider command / status between sequencer and divider
    typedef struct packed {
        logic               start;
        logic signed [65:0] num;
        logic        [33:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [65:0] quo;
    } div_rsp_t;
endpackage

/* hdl/verlet_circle_particle.sv */
// Channel | Dir | Beat content (low bits first)
// s_axis  | in  | tdata: vec_x, vec_y, other_radius; tuser: req_type
// m_axis  | out | tdata: pos_x, pos_y, prev_x, prev_y, other_new_x, other_new_y;
//         |     | tuser: overlapping, fault
// cfg     | in  | cfg_we, cfg_addr, cfg_wdata (no read-back)
// Request paths: accel/set position update registers directly; clamp; test; velocity;
// step (four products on the shared 34x34 multiplier); resolve (overlap test, 33-step
// square root, then per axis a division and the move); fault ends after the overlap test.
// Reset: synchronous, aresetn low; state returns to 20.0 and default registers.
// Stalls: s_tready is low while a request runs or a result waits in the output register.
module verlet_circle_particle #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vec_x, vec_y, other_radius, zero pad
    input  logic [2:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, prev_x, prev_y, other_new_x, other_new_y
    output logic [1:0]   m_tuser,   // overlapping, fault
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    localparam logic signed [31:0] START_POS = 32'sd20 <<< FRAC_BITS;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_MULW  = 10'b0000000100,
        ST_SQRT  = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_DIVW  = 10'b0000100000,
        ST_ALU   = 10'b0001000000,
        ST_TEST  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_CLAMP = 10'b1000000000
    } state_t;

    state_t state_reg;
    logic [31:0] dt_reg;
    logic [30:0] rad_reg;
    logic [15:0] ww_reg, wh_reg;
    logic signed [31:0] cx_reg, cy_reg, ox_reg, oy_reg, ax_reg, ay_reg;
    logic [2:0]  req_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic [31:0] s_reg; // radius sum, up to 2^32-2
    logic [4:0]  op_reg; // micro-step counter
    logic signed [65:0] acc_reg, t_reg, u_reg, dxm_reg, dym_reg, len_reg;
    logic signed [33:0] ma_reg, mb_reg;
    logic signed [67:0] prod_reg;
    logic [65:0] sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [5:0]  sq_cnt_reg;
    logic        ovl_reg, flt_reg, k_reg;
    logic signed [31:0] onx_reg, ony_reg;

    vcp_pkg::div_cmd_t dcmd;
    vcp_pkg::div_rsp_t drsp;
    logic signed [65:0] dnum_reg;
    logic        dstart_reg;

    assign dcmd.start = dstart_reg;
    assign dcmd.num   = dnum_reg;
    assign dcmd.den   = len_reg[33:0];

    vcp_divider u_div (.aclk(aclk), .aresetn(aresetn), .cmd(dcmd), .rsp(drsp));

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;

    // truncating shift toward zero by DT_FRAC
    function automatic logic signed [65:0] trunc_dt(input logic signed [67:0] p);
        logic signed [67:0] q;
        q = p[67] ? -((-p) >>> vcp_pkg::DT_FRAC) : (p >>> vcp_pkg::DT_FRAC);
        return q[65:0];
    endfunction
    function automatic logic signed [65:0] trunc_n(input logic signed [67:0] p);
        logic signed [67:0] q;
        q = p[67] ? -((-p) >>> (vcp_pkg::NORM_FRAC + 1))
                  : (p >>> (vcp_pkg::NORM_FRAC + 1));
        return q[65:0];
    endfunction

    // squared-magnitude helpers for the overlap test (absolute deltas < 2^33)
    logic [65:0] adx, ady, sq_sum, sq_trial;
    always_comb begin
        adx = dxm_reg[65] ? 66'(-dxm_reg) : dxm_reg;
        ady = dym_reg[65] ? 66'(-dym_reg) : dym_reg;
        sq_sum   = sq_r_reg + sq_bit_reg;
        sq_trial = sq_n_reg - sq_sum;
    end

    logic signed [65:0] rad_s;
    always_comb begin
        rad_s = $signed({35'd0, rad_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            m_tvalid   <= 1'b0;
            dstart_reg <= 1'b0;
            dt_reg <= 32'd279620;
            rad_reg <= 31'(10 << FRAC_BITS);
            ww_reg <= 16'd800;
            wh_reg <= 16'd600;
            cx_reg <= START_POS; cy_reg <= START_POS;
            ox_reg <= START_POS; oy_reg <= START_POS;
            ax_reg <= '0; ay_reg <= '0;
        end else begin
            dstart_reg <= 1'b0;
            prod_reg   <= ma_reg * mb_reg;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (cfg_we) begin
                case (cfg_addr)
                    vcp_pkg::CFG_STEP_TIME:    dt_reg  <= cfg_wdata;
                    vcp_pkg::CFG_BODY_RADIUS:  rad_reg <= cfg_wdata[30:0];
                    vcp_pkg::CFG_WORLD_WIDTH:  ww_reg  <= cfg_wdata[15:0];
                    vcp_pkg::CFG_WORLD_HEIGHT: wh_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        req_reg <= s_tuser;
                        vx_reg  <= s_tdata[31:0];
                        vy_reg  <= s_tdata[63:32];
                        s_reg   <= {1'b0, rad_reg} + {1'b0, s_tdata[94:64]};
                        ovl_reg <= 1'b0; flt_reg <= 1'b0;
                        onx_reg <= '0; ony_reg <= '0;
                        op_reg  <= '0;
                        state_reg <= ST_ALU;
                    end
                end
                ST_ALU: begin
                    // dispatch per request
                    case (req_reg)
                        vcp_pkg::REQ_ACCEL: begin
                            ax_reg <= vcp_pkg::sat32(66'(ax_reg) + 66'(vx_reg));
                            ay_reg <= vcp_pkg::sat32(66'(ay_reg) + 66'(vy_reg));
                            state_reg <= ST_OUT;
                        end
                        vcp_pkg::REQ_SETPOS: begin
                            cx_reg <= vx_reg; cy_reg <= vy_reg;
                            state_reg <= ST_OUT;
                        end
                        vcp_pkg::REQ_CLAMP: begin
                            op_reg <= '0;
                            state_reg <= ST_CLAMP;
                        end
                        vcp_pkg::REQ_TEST, vcp_pkg::REQ_RESOLVE: begin
                            dxm_reg <= 66'(cx_reg) - 66'(vx_reg);
                            dym_reg <= 66'(cy_reg) - 66'(vy_reg);
                            op_reg  <= '0;
                            state_reg <= ST_TEST;
                        end
                        default: begin
                            // step, set/add velocity: multiplier sequence
                            op_reg <= '0;
                            state_reg <= ST_MUL;
                        end
                    endcase
                end
                ST_CLAMP: begin
                    // ops 0 and 1 handle y, ops 2 and 3 handle x
                    if (op_reg == 5'd0) begin
                        if ($signed({{34{1'b0}}, wh_reg} <<< FRAC_BITS) - rad_s
                                < 66'(cy_reg))
                            cy_reg <= vcp_pkg::sat32(
                                ($signed({50'd0, wh_reg}) <<< FRAC_BITS) - rad_s);
                        op_reg <= 5'd1;
                    end else if (op_reg == 5'd1) begin
                        if (66'(cy_reg) < rad_s) cy_reg <= {1'b0, rad_reg};
                        op_reg <= 5'd2;
                    end else if (op_reg == 5'd2) begin
                        if (($signed({50'd0, ww_reg}) <<< FRAC_BITS) - rad_s
                                < 66'(cx_reg))
                            cx_reg <= vcp_pkg::sat32(
                                ($signed({50'd0, ww_reg}) <<< FRAC_BITS) - rad_s);
                        op_reg <= 5'd3;
                    end else begin
                        if (66'(cx_reg) < rad_s) cx_reg <= {1'b0, rad_reg};
                        state_reg <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    // load operands, then wait in ST_MULW for the registered product
                    case (op_reg)
                        5'd0: begin
                            ma_reg <= (req_reg == vcp_pkg::REQ_STEP) ? 34'(ax_reg) : 34'(vx_reg);
                            mb_reg <= $signed({2'b0, dt_reg});
                        end
                        5'd1: begin
                            ma_reg <= (req_reg == vcp_pkg::REQ_STEP) ? 34'(ay_reg) : 34'(vy_reg);
                            mb_reg <= $signed({2'b0, dt_reg});
                        end
                        5'd2: begin
                            ma_reg <= 34'(vcp_pkg::sat32(t_reg));
                            mb_reg <= $signed({2'b0, dt_reg});
                        end
                        default: begin
                            ma_reg <= 34'(vcp_pkg::sat32(u_reg));
                            mb_reg <= $signed({2'b0, dt_reg});
                        end
                    endcase
                    state_reg <= ST_MULW;
                end
                ST_MULW: begin
                    if (op_reg[4]) begin
                        // registered product ready; take it now
                        case (op_reg[3:0])
                            4'd0: t_reg <= trunc_dt(prod_reg);
                            4'd1: u_reg <= trunc_dt(prod_reg);
                            4'd2: t_reg <= trunc_dt(prod_reg);
                            default: u_reg <= trunc_dt(prod_reg);
                        endcase
                        if (req_reg != vcp_pkg::REQ_STEP && op_reg[3:0] == 4'd1) begin
                            if (req_reg == vcp_pkg::REQ_SETVEL) begin
                                ox_reg <= vcp_pkg::sat32(66'(cx_reg) - t_reg);
                                oy_reg <= vcp_pkg::sat32(66'(cy_reg) - trunc_dt(prod_reg));
                            end else begin
                                ox_reg <= vcp_pkg::sat32(66'(ox_reg) - t_reg);
                                oy_reg <= vcp_pkg::sat32(66'(oy_reg) - trunc_dt(prod_reg));
                            end
                            state_reg <= ST_OUT;
                        end else if (op_reg[3:0] == 4'd3) begin
                            cx_reg <= vcp_pkg::sat32(2 * 66'(cx_reg) - 66'(ox_reg) + t_reg);
                            cy_reg <= vcp_pkg::sat32(2 * 66'(cy_reg) - 66'(oy_reg)
                                                     + trunc_dt(prod_reg));
                            ox_reg <= cx_reg; oy_reg <= cy_reg;
                            ax_reg <= '0; ay_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            op_reg <= {1'b0, op_reg[3:0] + 4'd1};
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        op_reg[4] <= 1'b1;
                    end
                end
                ST_TEST: begin
                    case (op_reg)
                        5'd0: begin
                            ma_reg <= adx[33:0]; mb_reg <= adx[33:0];
                            op_reg <= 5'd1;
                        end
                        5'd1: begin
                            ma_reg <= ady[33:0]; mb_reg <= ady[33:0];
                            op_reg <= 5'd2;
                        end
                        5'd2: begin
                            acc_reg <= prod_reg[65:0]; // ax^2
                            ma_reg <= $signed({2'b0, s_reg}); mb_reg <= $signed({2'b0, s_reg});
                            op_reg <= 5'd3;
                        end
                        5'd3: begin
                            t_reg <= prod_reg[65:0]; // ay^2
                            op_reg <= 5'd4;
                        end
                        default: begin
                            ovl_reg <= (adx < 66'(s_reg)) && (ady < 66'(s_reg))
                                && (prod_reg[65:0] - acc_reg > t_reg);
                            if (req_reg == vcp_pkg::REQ_TEST) begin
                                state_reg <= ST_OUT;
                            end else if (dxm_reg == 0 && dym_reg == 0) begin
                                flt_reg <= 1'b1;
                                onx_reg <= vx_reg; ony_reg <= vy_reg;
                                state_reg <= ST_OUT;
                            end else begin
                                k_reg <= adx[31] | adx[32] | ady[31] | ady[32];
                                op_reg <= '0;
                                state_reg <= ST_SQRT;
                                sq_cnt_reg <= '0;
                            end
                        end
                    endcase
                end
                ST_SQRT: begin
                    if (sq_cnt_reg == 6'd0) begin
                        // squares of possibly halved magnitudes
                        ma_reg <= k_reg ? 34'(adx >> 1) : adx[33:0];
                        mb_reg <= k_reg ? 34'(adx >> 1) : adx[33:0];
                        sq_cnt_reg <= 6'd1;
                    end else if (sq_cnt_reg == 6'd1) begin
                        ma_reg <= k_reg ? 34'(ady >> 1) : ady[33:0];
                        mb_reg <= k_reg ? 34'(ady >> 1) : ady[33:0];
                        sq_cnt_reg <= 6'd2;
                    end else if (sq_cnt_reg == 6'd2) begin
                        acc_reg <= prod_reg[65:0];
                        sq_cnt_reg <= 6'd3;
                    end else if (sq_cnt_reg == 6'd3) begin
                        sq_n_reg   <= acc_reg + prod_reg[65:0];
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 66'd1 << 64;
                        sq_cnt_reg <= 6'd4;
                    end else if (sq_bit_reg != 0) begin
                        // one result bit per cycle
                        if (sq_n_reg >= sq_sum) begin
                            sq_n_reg <= sq_trial;
                            sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_r_reg <= sq_r_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end else begin
                        len_reg <= k_reg ? $signed(sq_r_reg << 1) : $signed(sq_r_reg);
                        op_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    dnum_reg   <= (op_reg == 5'd0 ? dxm_reg : dym_reg) <<< vcp_pkg::NORM_FRAC;
                    dstart_reg <= 1'b1;
                    state_reg  <= ST_DIVW;
                    u_reg      <= len_reg - 66'(s_reg); // penetration d
                end
                ST_DIVW: begin
                    if (drsp.done) begin
                        ma_reg <= u_reg[33:0];
                        mb_reg <= drsp.quo[33:0];
                        op_reg <= {op_reg[4:1], op_reg[0]} | 5'b00010;
                    end else if (op_reg[1] && !op_reg[2]) begin
                        op_reg[2] <= 1'b1;
                    end else if (op_reg[2]) begin
                        // registered product ready: apply move
                        if (!op_reg[0]) begin
                            cx_reg  <= vcp_pkg::sat32(66'(cx_reg) - trunc_n(prod_reg));
                            onx_reg <= vcp_pkg::sat32(66'(vx_reg) + trunc_n(prod_reg));
                            op_reg  <= 5'd1;
                            state_reg <= ST_DIV;
                        end else begin
                            cy_reg  <= vcp_pkg::sat32(66'(cy_reg) - trunc_n(prod_reg));
                            ony_reg <= vcp_pkg::sat32(66'(vy_reg) + trunc_n(prod_reg));
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    m_tvalid <= 1'b1;
                    m_tdata  <= {ony_reg, onx_reg, oy_reg, ox_reg, cy_reg, cx_reg};
                    m_tuser  <= {flt_reg, ovl_reg};
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // hdl assertions
    `include "verlet_circle_particle_defines.svh"
    `VCP_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `VCP_ASSERT_NXT(a_out_valid, aclk, aresetn, state_reg == ST_OUT, m_tvalid)
    `VCP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

/* hdl/vcp_divider.sv */
// Restoring signed divider, one quotient bit a cycle, quotient truncated toward zero
module vcp_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  vcp_pkg::div_cmd_t cmd,
    output vcp_pkg::div_rsp_t rsp
);
    localparam int NB = 66;
    logic [NB-1:0] rem_reg, quo_reg;
    logic [33:0]   den_reg;
    logic          neg_reg, busy_reg, done_reg;
    logic [6:0]    cnt_reg;
    logic [NB:0]   trial;
    logic [NB-1:0] shifted;

    always_comb begin
        shifted = {rem_reg[NB-2:0], quo_reg[NB-1]};
        trial   = {1'b0, shifted} - {{(NB-33){1'b0}}, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(NB);
                rem_reg  <= '0;
                quo_reg  <= cmd.num[NB-1] ? 66'(-cmd.num) : cmd.num;
                den_reg  <= cmd.den;
                neg_reg  <= cmd.num[NB-1];
            end else if (busy_reg) begin
                if (!trial[NB]) begin
                    rem_reg <= trial[NB-1:0];
                    quo_reg <= {quo_reg[NB-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[NB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    // Clock, reset and block ports
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // vec_x, vec_y, other_radius, zero pad
    logic [2:0]   s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // pos_x, pos_y, prev_x, prev_y, other_new_x, other_new_y
    logic [1:0]   m_tuser;   // overlapping, fault
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    // One expected particle report
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic        overlapping;
        logic [31:0] other_new_x;
        logic [31:0] other_new_y;
        logic        fault;
    } report_t;

    report_t report_q[$];

    // Predictor state: current and previous positions, acceleration and the four registers
    longint px, py, ox, oy, ax_acc, ay_acc;
    longint dt_val, rad_val, ww_val, wh_val;

    int     errors;
    int     quiet_cycles;
    bit     hold_off;
    bit     burst_mode;

    localparam int QUIET_LIMIT = 20000;

    verlet_circle_particle #(.FRAC_BITS(16)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------
    // Fixed-point helpers for the predictor
    // ---------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // SystemVerilog division truncates toward zero, as needed here
    function automatic longint scale_dt(input longint v);
        return (v * dt_val) / (64'sd1 <<< 24);
    endfunction

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic bit circles_touch(input longint dx, input longint dy,
                                         input longint unsigned s);
        longint unsigned mx, my;
        mx = magn(dx);
        my = magn(dy);
        if (mx >= s || my >= s) return 1'b0;
        return (s * s - mx * mx) > (my * my);
    endfunction

    function automatic longint wall_limit(input longint p, input longint world);
        longint hi;
        hi = (world <<< 16) - rad_val;
        if (p > hi) p = clip32(hi);
        if (p < rad_val) p = rad_val;
        return p;
    endfunction

    // Work out the report for one request and advance the particle state
    function automatic report_t particle_response(input logic [2:0] req,
                                                  input logic [31:0] vxb,
                                                  input logic [31:0] vyb,
                                                  input logic [30:0] orad);
        report_t r;
        longint vx, vy, tx, ty, nx, ny, dx, dy, len, d, mvx, mvy, onx, ony;
        longint unsigned s, mx, my;
        int k;
        vx = longint'($signed(vxb));
        vy = longint'($signed(vyb));
        onx = 0;
        ony = 0;
        r = '0;
        case (req)
            vcp_pkg::REQ_ACCEL: begin
                ax_acc = clip32(ax_acc + vx);
                ay_acc = clip32(ay_acc + vy);
            end
            vcp_pkg::REQ_STEP: begin
                tx = scale_dt(clip32(scale_dt(ax_acc)));
                ty = scale_dt(clip32(scale_dt(ay_acc)));
                nx = clip32(2 * px - ox + tx);
                ny = clip32(2 * py - oy + ty);
                ox = px;
                oy = py;
                px = nx;
                py = ny;
                ax_acc = 0;
                ay_acc = 0;
            end
            vcp_pkg::REQ_CLAMP: begin
                py = wall_limit(py, wh_val);
                px = wall_limit(px, ww_val);
            end
            vcp_pkg::REQ_TEST: begin
                r.overlapping = circles_touch(px - vx, py - vy, rad_val + orad);
            end
            vcp_pkg::REQ_RESOLVE: begin
                dx = px - vx;
                dy = py - vy;
                s = rad_val + orad;
                r.overlapping = circles_touch(dx, dy, s);
                if (dx == 0 && dy == 0) begin
                    r.fault = 1'b1;
                    onx = vx;
                    ony = vy;
                end else begin
                    mx = magn(dx);
                    my = magn(dy);
                    k = (mx >= 64'h8000_0000 || my >= 64'h8000_0000) ? 1 : 0;
                    mx = mx >> k;
                    my = my >> k;
                    len = longint'(int_root(mx * mx + my * my) << k);
                    d = len - longint'(s);
                    nx = (dx * (64'sd1 <<< 29)) / len;
                    ny = (dy * (64'sd1 <<< 29)) / len;
                    mvx = (d * nx) / (64'sd1 <<< 30);
                    mvy = (d * ny) / (64'sd1 <<< 30);
                    px = clip32(px - mvx);
                    py = clip32(py - mvy);
                    onx = clip32(vx + mvx);
                    ony = clip32(vy + mvy);
                end
            end
            vcp_pkg::REQ_SETVEL: begin
                ox = clip32(px - scale_dt(vx));
                oy = clip32(py - scale_dt(vy));
            end
            vcp_pkg::REQ_ADDVEL: begin
                ox = clip32(ox - scale_dt(vx));
                oy = clip32(oy - scale_dt(vy));
            end
            default: begin
                px = vx;
                py = vy;
            end
        endcase
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.prev_x = ox[31:0];
        r.prev_y = oy[31:0];
        r.other_new_x = onx[31:0];
        r.other_new_y = ony[31:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one request beat, presented at the falling edge
    // ---------------------------------------------------------------
    task automatic send_request(input logic [2:0] req, input logic [31:0] vx,
                                input logic [31:0] vy, input logic [30:0] orad);
        s_tdata  <= {1'b0, orad, vy, vx};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        // hold the beat until it is taken
        do @(posedge aclk); while (!s_tready);
        report_q.push_back(particle_response(req, vx, vy, orad));
        @(negedge aclk);
        // insert a gap now and then to break bursts
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for every outstanding report, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Register write; only called with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            vcp_pkg::CFG_STEP_TIME:    dt_val  = val;
            vcp_pkg::CFG_BODY_RADIUS:  rad_val = val[30:0];
            vcp_pkg::CFG_WORLD_WIDTH:  ww_val  = val[15:0];
            default:                   wh_val  = val[15:0];
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 1000) << 16;
            4: return -($urandom_range(0, 1000) << 16);
            5: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'h0;
            2: return 31'($urandom_range(0, 50) << 16);
            default: return 31'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send_request(vcp_pkg::REQ_ACCEL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        send_request(vcp_pkg::REQ_ACCEL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_request(vcp_pkg::REQ_STEP, 32'h0, 32'h0, 31'h0);
        send_request(vcp_pkg::REQ_STEP, 32'h0, 32'h0, 31'h0);
        send_request(vcp_pkg::REQ_CLAMP, 32'h0, 32'h0, 31'h0);
        send_request(vcp_pkg::REQ_SETPOS, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        send_request(vcp_pkg::REQ_CLAMP, 32'h0, 32'h0, 31'h0);
        send_request(vcp_pkg::REQ_SETPOS, 32'd100 << 16, 32'd100 << 16, 31'h0);
        send_request(vcp_pkg::REQ_TEST, 32'd105 << 16, 32'd100 << 16, 31'd5 << 16);
        send_request(vcp_pkg::REQ_TEST, 32'd200 << 16, 32'd100 << 16, 31'd1 << 16);
        send_request(vcp_pkg::REQ_RESOLVE, 32'd105 << 16, 32'd103 << 16, 31'd5 << 16);
        // coincident centres raise the fault
        send_request(vcp_pkg::REQ_SETPOS, 32'd50 << 16, 32'd50 << 16, 31'h0);
        send_request(vcp_pkg::REQ_RESOLVE, 32'd50 << 16, 32'd50 << 16, 31'd3 << 16);
        // far-apart centres take the halving path
        send_request(vcp_pkg::REQ_SETPOS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0);
        send_request(vcp_pkg::REQ_RESOLVE, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        send_request(vcp_pkg::REQ_SETVEL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        send_request(vcp_pkg::REQ_ADDVEL, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        send_request(vcp_pkg::REQ_ADDVEL, 32'd60 << 16, 32'd0, 31'h0);
        send_request(vcp_pkg::REQ_SETVEL, 32'hFFFF_FFFF, 32'h1, 31'h0);
        send_request(vcp_pkg::REQ_STEP, 32'h0, 32'h0, 31'h0);
        drain();
    endtask

    // Random requests of every type, with test and resolve often aimed near the particle
    task automatic test_random(input int count);
        logic [2:0] req;
        logic [31:0] vx, vy;
        for (int i = 0; i < count; i++) begin
            req = 3'($urandom_range(0, 7));
            vx = rand_word();
            vy = rand_word();
            // aim collisions near the particle so resolve reaches real overlaps
            if ((req == vcp_pkg::REQ_RESOLVE || req == vcp_pkg::REQ_TEST)
                    && $urandom_range(0, 2) != 0) begin
                vx = px[31:0] + $urandom_range(0, 40 << 16) - (20 << 16);
                vy = py[31:0] + $urandom_range(0, 40 << 16) - (20 << 16);
                if ($urandom_range(0, 9) == 0) begin
                    vx = px[31:0];
                    vy = py[31:0];
                end
            end
            send_request(req, vx, vy, rand_radius());
            if ($urandom_range(0, 60) == 0) go_idle();
        end
        drain();
    endtask

    // Receiver holds off while requests keep coming so the block backs up
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_request(3'($urandom_range(0, 7)), rand_word(), rand_word(),
                                 rand_radius());
            end
        join
        drain();
    endtask

    task automatic test_registers();
        write_reg(vcp_pkg::CFG_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(vcp_pkg::CFG_BODY_RADIUS, 32'h7FFF_FFFF);
        write_reg(vcp_pkg::CFG_WORLD_WIDTH, 32'h0000_FFFF);
        write_reg(vcp_pkg::CFG_WORLD_HEIGHT, 32'h0);
        test_random(60);
        write_reg(vcp_pkg::CFG_STEP_TIME, 32'h0);
        write_reg(vcp_pkg::CFG_BODY_RADIUS, 32'h0);
        write_reg(vcp_pkg::CFG_WORLD_WIDTH, 32'h0);
        write_reg(vcp_pkg::CFG_WORLD_HEIGHT, 32'h0000_FFFF);
        test_random(60);
        write_reg(vcp_pkg::CFG_STEP_TIME, $urandom);
        write_reg(vcp_pkg::CFG_BODY_RADIUS, $urandom_range(1, 40) << 16);
        write_reg(vcp_pkg::CFG_WORLD_WIDTH, $urandom_range(1, 2000));
        write_reg(vcp_pkg::CFG_WORLD_HEIGHT, $urandom_range(1, 2000));
        test_random(100);
        write_reg(vcp_pkg::CFG_STEP_TIME, 32'd279620);
        write_reg(vcp_pkg::CFG_BODY_RADIUS, 32'd10 << 16);
        write_reg(vcp_pkg::CFG_WORLD_WIDTH, 32'd800);
        write_reg(vcp_pkg::CFG_WORLD_HEIGHT, 32'd600);
    endtask

    // ---------------------------------------------------------------
    // Receiver stall pattern: stretches of free flow and stretches of random stall
    // ---------------------------------------------------------------
    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_off) m_tready <= 1'b0;
            else if ((phase / 64) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // ---------------------------------------------------------------
    // Checker: compare each accepted report with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = report_q.pop_front();
                if (m_tdata[31:0] !== e.pos_x) begin
                    $error("pos_x exp %h got %h", e.pos_x, m_tdata[31:0]); errors++;
                end
                if (m_tdata[63:32] !== e.pos_y) begin
                    $error("pos_y exp %h got %h", e.pos_y, m_tdata[63:32]); errors++;
                end
                if (m_tdata[95:64] !== e.prev_x) begin
                    $error("prev_x exp %h got %h", e.prev_x, m_tdata[95:64]); errors++;
                end
                if (m_tdata[127:96] !== e.prev_y) begin
                    $error("prev_y exp %h got %h", e.prev_y, m_tdata[127:96]); errors++;
                end
                if (m_tdata[159:128] !== e.other_new_x) begin
                    $error("other_new_x exp %h got %h", e.other_new_x, m_tdata[159:128]);
                    errors++;
                end
                if (m_tdata[191:160] !== e.other_new_y) begin
                    $error("other_new_y exp %h got %h", e.other_new_y, m_tdata[191:160]);
                    errors++;
                end
                if (m_tuser[0] !== e.overlapping) begin
                    $error("overlapping exp %b got %b", e.overlapping, m_tuser[0]); errors++;
                end
                if (m_tuser[1] !== e.fault) begin
                    $error("fault exp %b got %b", e.fault, m_tuser[1]); errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        hold_off = 1'b0;
        burst_mode = 1'b1;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = vcp_pkg::REQ_ACCEL;
        cfg_we    = 1'b0;
        cfg_addr  = vcp_pkg::CFG_STEP_TIME;
        cfg_wdata = '0;
        // predictor reset state: 20.0 everywhere, no acceleration
        px = 20 <<< 16; py = 20 <<< 16; ox = 20 <<< 16; oy = 20 <<< 16;
        ax_acc = 0; ay_acc = 0;
        dt_val = 279620; rad_val = 10 <<< 16; ww_val = 800; wh_val = 600;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_backpressure();
        test_random(200);
        burst_mode = 1'b0;
        test_registers();
        burst_mode = 1'b1;
        test_random(200);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/vcp_pkg.sv
hdl/vcp_divider.sv
hdl/verlet_circle_particle.sv
bench/tb.sv
